// File: rtl/core/lbes_pkg.sv
// Shared types and constants for the load balancer endpoint selector.
// No dependencies; imported by the interfaces and every module of the block.
package lbes_pkg;

	// Endpoint table limits
	localparam int MaxEndpoints = 16;
	localparam int CountCap     = (MaxEndpoints < 16) ? MaxEndpoints : 16;

	// Field widths
	localparam int HashW  = 32;
	localparam int IdxW   = 4;
	localparam int CountW = 5;
	localparam int MaskW  = 16;

	// Configuration port
	localparam int AddrW = 4;
	localparam int DataW = 32;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_SELECT_MODE    = 2'd0;
	localparam logic [1:0] REG_ENDPOINT_COUNT = 2'd1;
	localparam logic [1:0] REG_INACTIVE_MASK  = 2'd2;

	// Selection modes
	localparam logic MODE_ROUND_ROBIN = 1'b0;
	localparam logic MODE_HASH        = 1'b1;

	// Source of the result held for output
	localparam logic [1:0] RES_SCAN = 2'd0;
	localparam logic [1:0] RES_REM  = 2'd1;
	localparam logic [1:0] RES_NONE = 2'd2;

	typedef struct packed {
		logic       load;       // load dividend, clear remainder
		logic       div_step;   // one restoring division step
		logic       scan_rem;   // start scan at the remainder
		logic       scan_zero;  // start scan at endpoint zero
		logic       scan_step;  // advance scan pointer
		logic       commit_rr;  // store the next round-robin start
		logic       res_load;   // capture the result
		logic [1:0] res_src;    // where the result comes from
		logic       out_load;   // move the result into the output register
	} lbes_cmd_t;

	typedef struct packed {
		logic scan_active;  // endpoint under the scan pointer is active
		logic rem_active;   // hashed endpoint is active
		logic scan_last;    // scan pointer is on the last candidate
	} lbes_stat_t;

	typedef struct packed {
		logic              mode;
		logic [CountW-1:0] count;  // effective endpoint count
		logic [MaskW-1:0]  mask;
	} lbes_cfg_t;

endpackage

// File: rtl/core/lbes_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on lbes_pkg for field widths.
interface lbes_req_if;
	import lbes_pkg::*;
	logic             valid;
	logic             ready;
	logic [HashW-1:0] packet_hash;
	modport source (output valid, output packet_hash, input ready);
	modport sink (input valid, input packet_hash, output ready);
endinterface

interface lbes_rsp_if;
	import lbes_pkg::*;
	logic            valid;
	logic            ready;
	logic [IdxW-1:0] endpoint_index;
	logic            selected;
	modport source (output valid, output endpoint_index, output selected, input ready);
	modport sink (input valid, input endpoint_index, input selected, output ready);
endinterface

// File: rtl/core/lbes_cfg.sv
// APB-style configuration registers and effective endpoint count.
// Depends on lbes_pkg.
module lbes_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [lbes_pkg::AddrW-1:0] paddr,
	input  logic [lbes_pkg::DataW-1:0] pwdata,
	output logic [lbes_pkg::DataW-1:0] prdata,
	output logic                      pready,
	output lbes_pkg::lbes_cfg_t       cfg
);
	import lbes_pkg::*;

	logic              mode_q;
	logic [CountW-1:0] count_q;
	logic [MaskW-1:0]  mask_q;
	logic              wr_en;
	logic [1:0]        reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;

	// Write registers on the access phase; unknown indexes drop the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ROUND_ROBIN;
			count_q <= CountW'(1);
			mask_q  <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SELECT_MODE:    mode_q  <= pwdata[0];
				REG_ENDPOINT_COUNT: count_q <= pwdata[CountW-1:0];
				REG_INACTIVE_MASK:  mask_q  <= pwdata[MaskW-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_SELECT_MODE:    prdata = {{(DataW-1){1'b0}}, mode_q};
			REG_ENDPOINT_COUNT: prdata = {{(DataW-CountW){1'b0}}, count_q};
			REG_INACTIVE_MASK:  prdata = {{(DataW-MaskW){1'b0}}, mask_q};
			default:            prdata = '0;
		endcase
	end

	// Clamp the count into one .. cap
	always_comb begin
		cfg.mode = mode_q;
		cfg.mask = mask_q;
		if (count_q == '0) begin
			cfg.count = CountW'(1);
		end else if (count_q > CountW'(CountCap)) begin
			cfg.count = CountW'(CountCap);
		end else begin
			cfg.count = count_q;
		end
	end

endmodule

// File: rtl/core/lbes_datapath.sv
// Datapath: bit-serial remainder unit, endpoint scan pointer, round-robin
// start register and output payload. Depends on lbes_pkg.
module lbes_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lbes_pkg::lbes_cfg_t        cfg,
	input  lbes_pkg::lbes_cmd_t        cmd,
	input  logic [lbes_pkg::HashW-1:0] packet_hash,
	output lbes_pkg::lbes_stat_t       stat,
	output logic [lbes_pkg::IdxW-1:0]  endpoint_index,
	output logic                       selected
);
	import lbes_pkg::*;

	logic [HashW-1:0]  dvd_q;
	logic [IdxW-1:0]   rem_q;
	logic [IdxW-1:0]   idx_q;
	logic [CountW-1:0] n_q;
	logic [IdxW-1:0]   next_start_q;
	logic [IdxW-1:0]   res_idx_q;
	logic              res_sel_q;
	logic [IdxW-1:0]   out_idx_q;
	logic              out_sel_q;
	logic [CountW-1:0] part;
	logic [CountW-1:0] part_red;
	logic [CountW-1:0] idx_inc;
	logic [IdxW-1:0]   idx_wrap;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		part = {rem_q, dvd_q[HashW-1]};
		if (part >= cfg.count) begin
			part_red = part - cfg.count;
		end else begin
			part_red = part;
		end
	end

	// Successor of the scan pointer, wrapping at the count
	always_comb begin
		idx_inc = {1'b0, idx_q} + CountW'(1);
		if (idx_inc == cfg.count) begin
			idx_wrap = '0;
		end else begin
			idx_wrap = idx_inc[IdxW-1:0];
		end
	end

	assign stat.scan_active = ~cfg.mask[idx_q];
	assign stat.rem_active  = ~cfg.mask[rem_q];
	assign stat.scan_last   = (n_q == cfg.count - CountW'(1));

	// Remainder unit
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (cfg.mode == MODE_HASH) begin
				dvd_q <= packet_hash;
			end else begin
				dvd_q <= {{(HashW-IdxW){1'b0}}, next_start_q};
			end
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[HashW-2:0], 1'b0};
			rem_q <= part_red[IdxW-1:0];
		end
	end

	// Scan pointer and candidate count
	always_ff @(posedge clk) begin
		if (cmd.scan_rem) begin
			idx_q <= rem_q;
			n_q   <= '0;
		end else if (cmd.scan_zero) begin
			idx_q <= '0;
			n_q   <= '0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_wrap;
			n_q   <= n_q + CountW'(1);
		end
	end

	// Round-robin start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_start_q <= '0;
		end else if (cmd.commit_rr) begin
			next_start_q <= idx_wrap;
		end
	end

	// Hold the result, then move it into the output register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			case (cmd.res_src)
				RES_SCAN: begin
					res_idx_q <= idx_q;
					res_sel_q <= 1'b1;
				end
				RES_REM: begin
					res_idx_q <= rem_q;
					res_sel_q <= 1'b1;
				end
				default: begin
					res_idx_q <= '0;
					res_sel_q <= 1'b0;
				end
			endcase
		end
		if (cmd.out_load) begin
			out_idx_q <= res_idx_q;
			out_sel_q <= res_sel_q;
		end
	end

	assign endpoint_index = out_idx_q;
	assign selected       = out_sel_q;

endmodule

// File: rtl/core/lbes_ctrl.sv
// Controller state machine: sequences the division, the scan and the
// output handshake. Depends on lbes_pkg.
module lbes_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 mode,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  lbes_pkg::lbes_stat_t stat,
	output lbes_pkg::lbes_cmd_t  cmd
);
	import lbes_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_INIT = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	localparam int         StepW    = $clog2(HashW);
	localparam logic [StepW-1:0] LastStep = StepW'(HashW - 1);

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [StepW-1:0] step_q;
	logic             out_valid_q;
	logic             slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = ~out_valid_q | out_ready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == LastStep) begin
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				if (mode == MODE_HASH && stat.rem_active) begin
					cmd.res_load = 1'b1;
					cmd.res_src  = RES_REM;
					state_d      = S_EMIT;
				end else if (mode == MODE_HASH) begin
					cmd.scan_zero = 1'b1;
					state_d       = S_SCAN;
				end else begin
					cmd.scan_rem = 1'b1;
					state_d      = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_active) begin
					cmd.res_load  = 1'b1;
					cmd.res_src   = RES_SCAN;
					cmd.commit_rr = (mode == MODE_ROUND_ROBIN);
					state_d       = S_EMIT;
				end else if (stat.scan_last) begin
					cmd.res_load = 1'b1;
					cmd.res_src  = (mode == MODE_HASH) ? RES_REM : RES_NONE;
					state_d      = S_EMIT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + StepW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/lb_endpoint_selector_top.sv
// Load balancer endpoint selector: top level joining registers, controller
// and datapath. Depends on lbes_pkg, lbes_if, lbes_cfg, lbes_ctrl, lbes_datapath.
//
// Usage:
//   req  - request words carrying packet_hash (valid/ready).
//   rsp  - one response word per request: endpoint_index and selected.
//   APB  - select_mode at 0x0, endpoint_count at 0x4, inactive_mask at 0x8;
//          pready is tied high; write only while no request is in flight.
// Operation:
//   A request is reduced modulo the endpoint count by a one-bit-per-cycle
//   remainder unit, then the endpoint scan visits one candidate per cycle
//   (up to the endpoint count). In hash mode an active hashed endpoint is
//   taken without a scan. One request is worked at a time and the next is
//   taken the cycle after the result enters the output register.
// Reset:
//   Registers return to round-robin, count one, all endpoints active, and
//   the round-robin start to endpoint zero. No clearing pass is needed.
// Stalls:
//   The response sits in an output register; the next request is taken while
//   it waits, and the new result is held until the register is free.
module lb_endpoint_selector_top (
	input  logic                      clk,
	input  logic                      arst_n,
	lbes_req_if.sink                  req,
	lbes_rsp_if.source                rsp,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [lbes_pkg::AddrW-1:0] paddr,
	input  logic [lbes_pkg::DataW-1:0] pwdata,
	output logic [lbes_pkg::DataW-1:0] prdata,
	output logic                      pready
);
	import lbes_pkg::*;

	lbes_cfg_t  cfg;
	lbes_cmd_t  cmd;
	lbes_stat_t stat;

	lbes_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lbes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (cfg.mode),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lbes_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.packet_hash    (req.packet_hash),
		.stat           (stat),
		.endpoint_index (rsp.endpoint_index),
		.selected       (rsp.selected)
	);

endmodule

// File: sim/lb_endpoint_selector_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for lb_endpoint_selector_top: a directed table, then random phases.
// Depends on lbes_pkg, the lbes_req_if / lbes_rsp_if channels and the block itself.
module lb_endpoint_selector_top_test;
	import lbes_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int NumProbes     = 25;
	localparam int NumPhases     = 16;
	localparam int WordsPerPhase = 100;
	localparam int StallLimit    = 2000;
	localparam int SettleCycles  = 64;
	localparam int MaxReports    = 10;

	typedef struct packed {
		logic [IdxW-1:0] idx;
		logic            sel;
	} choice_t;

	typedef struct packed {
		logic              reconfig;
		logic              spare_poke;
		logic              mode;
		logic [CountW-1:0] count;
		logic [MaskW-1:0]  mask;
		logic [HashW-1:0]  hash;
		logic              typed;
		choice_t           want;
	} probe_t;

	logic             clk;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;

	lbes_req_if req_ch ();
	lbes_rsp_if rsp_ch ();

	lb_endpoint_selector_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the registers and the round-robin start
	logic              mode_reg  = MODE_ROUND_ROBIN;
	logic [CountW-1:0] count_reg = 5'd1;
	logic [MaskW-1:0]  mask_reg  = '0;
	logic [IdxW-1:0]   rr_start  = '0;

	choice_t pending_choices [$];
	probe_t  probes [NumProbes];

	int   mismatches       = 0;
	int   words_sent       = 0;
	int   words_checked    = 0;
	int   settings_written = 0;
	int   idle_cycles      = 0;
	int   stall_left       = 0;
	logic calm_phase       = 1'b0;
	logic quiet_tail       = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Pick the endpoint for one request word and advance the round-robin start
	function automatic choice_t choose_endpoint(input logic [HashW-1:0] hash);
		int unsigned n_ep;
		int unsigned pos;
		choice_t     c;
		n_ep = (count_reg == 0) ? 1 : ((count_reg > CountCap) ? CountCap : count_reg);
		c = '0;
		if (mode_reg == MODE_ROUND_ROBIN) begin
			pos = rr_start % n_ep;
			for (int k = 0; k < n_ep; k++) begin
				if (!mask_reg[pos]) begin
					c.idx = IdxW'(pos);
					c.sel = 1'b1;
					rr_start = IdxW'((pos + 1) % n_ep);
					break;
				end
				pos = (pos + 1) % n_ep;
			end
		end else begin
			pos = hash % n_ep;
			c.idx = IdxW'(pos);
			c.sel = 1'b1;
			// fall back to the lowest active endpoint below the count
			if (mask_reg[pos]) begin
				for (int k = 0; k < n_ep; k++) begin
					if (!mask_reg[k]) begin
						c.idx = IdxW'(k);
						break;
					end
				end
			end
		end
		return c;
	endfunction

	task automatic log_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= MaxReports)
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
	endtask

	task automatic apb_write(input logic [1:0] reg_idx, input logic [DataW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= AddrW'({reg_idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	// Drop valid and hold until every expected word has come back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_choices.size() != 0) @(posedge clk);
	endtask

	task automatic pause_sender(input int cycles);
		req_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Write all three registers with the block idle; upper data bits carry noise
	task automatic set_registers(input logic mode, input logic [CountW-1:0] count,
			input logic [MaskW-1:0] mask, input logic spare_poke);
		logic [DataW-1:0] noise;
		noise = $urandom;
		drain_results();
		apb_write(REG_SELECT_MODE, {noise[DataW-1:1], mode});
		apb_write(REG_ENDPOINT_COUNT, {noise[DataW-1:CountW], count});
		apb_write(REG_INACTIVE_MASK, {noise[DataW-1:MaskW], mask});
		if (spare_poke)
			apb_write(REG_SPARE, '1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		mode_reg  = mode;
		count_reg = count;
		mask_reg  = mask;
		settings_written++;
	endtask

	// Offer one request word; valid stays high for the caller to reuse
	task automatic send_word(input logic [HashW-1:0] hash, input logic typed,
			input choice_t want);
		choice_t c;
		req_ch.valid       <= 1'b1;
		req_ch.packet_hash <= hash;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		c = choose_endpoint(hash);
		pending_choices.push_back(typed ? want : c);
		words_sent++;
	endtask

	// Response ready: random stall bursts, none when calm or at the tail
	always @(posedge clk) begin
		if (quiet_tail || calm_phase) begin
			rsp_ch.ready <= 1'b1;
			stall_left   <= 0;
		end else if (stall_left != 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else if ($urandom_range(0, rsp_ch.valid ? 2 : 9) == 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= $urandom_range(0, 3);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Compare each response word with the oldest expectation
	always @(posedge clk) begin
		choice_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			words_checked++;
			if (pending_choices.size() == 0) begin
				log_mismatch("unexpected word", -1,
					int'({rsp_ch.endpoint_index, rsp_ch.selected}));
			end else begin
				want = pending_choices.pop_front();
				if (rsp_ch.endpoint_index !== want.idx)
					log_mismatch("endpoint_index", int'(want.idx),
						int'(rsp_ch.endpoint_index));
				if (rsp_ch.selected !== want.sel)
					log_mismatch("selected", int'(want.sel), int'(rsp_ch.selected));
			end
		end
	end

	// Watchdog: end the run when no word moves for too long
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("[lb_endpoint_selector_top] ERROR");
			$finish;
		end
	end

	initial begin
		logic              m;
		logic [CountW-1:0] cnt;
		logic [MaskW-1:0]  msk;
		logic [HashW-1:0]  h;
		int                eff;

		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		req_ch.valid       = 1'b0;
		req_ch.packet_hash = '0;
		rsp_ch.ready       = 1'b1;

		// reconfig, spare, mode, count, mask, hash, typed, expected {index, selected}
		probes = '{
			// reset state: one endpoint
			'{1'b0, 1'b0, MODE_ROUND_ROBIN, 5'd1, 16'h0000, 32'h0000_0000, 1'b1, '{4'd0, 1'b1}},
			'{1'b0, 1'b0, MODE_ROUND_ROBIN, 5'd1, 16'h0000, 32'hFFFF_FFFF, 1'b1, '{4'd0, 1'b1}},
			'{1'b1, 1'b0, MODE_ROUND_ROBIN, 5'd16, 16'h0000, 32'h0000_0000, 1'b1, '{4'd0, 1'b1}},
			'{1'b0, 1'b0, MODE_ROUND_ROBIN, 5'd16, 16'h0000, 32'h0000_1234, 1'b0, '{4'd0, 1'b0}},
			// all inactive in round-robin
			'{1'b1, 1'b0, MODE_ROUND_ROBIN, 5'd16, 16'hFFFF, 32'hA5A5_5A5A, 1'b1, '{4'd0, 1'b0}},
			// count zero is raised to one
			'{1'b1, 1'b0, MODE_ROUND_ROBIN, 5'd0, 16'h0000, 32'h0000_0001, 1'b1, '{4'd0, 1'b1}},
			// count above sixteen is capped
			'{1'b1, 1'b0, MODE_ROUND_ROBIN, 5'd31, 16'h0001, 32'h0F0F_0F0F, 1'b0, '{4'd0, 1'b0}},
			'{1'b0, 1'b0, MODE_ROUND_ROBIN, 5'd31, 16'h0001, 32'hF0F0_F0F0, 1'b0, '{4'd0, 1'b0}},
			'{1'b0, 1'b0, MODE_ROUND_ROBIN, 5'd31, 16'h0001, 32'h5555_5555, 1'b0, '{4'd0, 1'b0}},
			'{1'b0, 1'b0, MODE_ROUND_ROBIN, 5'd31, 16'h0001, 32'hAAAA_AAAA, 1'b0, '{4'd0, 1'b0}},
			'{1'b0, 1'b0, MODE_ROUND_ROBIN, 5'd31, 16'h0001, 32'h8000_0001, 1'b0, '{4'd0, 1'b0}},
			// stale start: count shrinks below the stored start
			'{1'b1, 1'b0, MODE_ROUND_ROBIN, 5'd4, 16'h0000, 32'h0000_0000, 1'b0, '{4'd0, 1'b0}},
			// only the top endpoint active, then wrap round to it again
			'{1'b1, 1'b0, MODE_ROUND_ROBIN, 5'd16, 16'h7FFF, 32'h0000_0000, 1'b1, '{4'd15, 1'b1}},
			'{1'b0, 1'b0, MODE_ROUND_ROBIN, 5'd16, 16'h7FFF, 32'h0000_0000, 1'b1, '{4'd15, 1'b1}},
			// hash extremes
			'{1'b1, 1'b0, MODE_HASH, 5'd16, 16'h0000, 32'hFFFF_FFFF, 1'b1, '{4'd15, 1'b1}},
			'{1'b0, 1'b0, MODE_HASH, 5'd16, 16'h0000, 32'h0000_0000, 1'b1, '{4'd0, 1'b1}},
			'{1'b0, 1'b0, MODE_HASH, 5'd16, 16'h0000, 32'h8000_0000, 1'b1, '{4'd0, 1'b1}},
			'{1'b1, 1'b0, MODE_HASH, 5'd7, 16'h0000, 32'hFFFF_FFFF, 1'b0, '{4'd0, 1'b0}},
			// hashed endpoint inactive: lowest active taken
			'{1'b1, 1'b0, MODE_HASH, 5'd16, 16'h8000, 32'hFFFF_FFFF, 1'b1, '{4'd0, 1'b1}},
			// all inactive in hash mode keeps the hashed index
			'{1'b1, 1'b0, MODE_HASH, 5'd16, 16'hFFFF, 32'h0000_000F, 1'b1, '{4'd15, 1'b1}},
			'{1'b1, 1'b0, MODE_HASH, 5'd0, 16'h0000, 32'hDEAD_BEEF, 1'b1, '{4'd0, 1'b1}},
			'{1'b1, 1'b0, MODE_HASH, 5'd31, 16'h00FF, 32'h1234_5673, 1'b1, '{4'd8, 1'b1}},
			// active endpoints only above the count are not taken
			'{1'b1, 1'b0, MODE_HASH, 5'd5, 16'h001F, 32'h0000_0007, 1'b1, '{4'd2, 1'b1}},
			'{1'b1, 1'b0, MODE_ROUND_ROBIN, 5'd5, 16'h001F, 32'h0000_0000, 1'b1, '{4'd0, 1'b0}},
			// write to an unused address is ignored
			'{1'b1, 1'b1, MODE_ROUND_ROBIN, 5'd2, 16'h0000, 32'h0000_0000, 1'b1, '{4'd0, 1'b1}}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (probes[i]) begin
			if (probes[i].reconfig)
				set_registers(probes[i].mode, probes[i].count, probes[i].mask,
					probes[i].spare_poke);
			send_word(probes[i].hash, probes[i].typed, probes[i].want);
		end

		// Random phases, each under a fresh register setting
		for (int ph = 0; ph < NumPhases; ph++) begin
			quiet_tail = (ph == NumPhases - 1);
			calm_phase = ($urandom_range(0, 3) == 0);
			m = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0:       cnt = 5'd0;
				1:       cnt = CountW'($urandom_range(17, 31));
				2:       cnt = 5'd16;
				3:       cnt = 5'd1;
				default: cnt = CountW'($urandom_range(2, 15));
			endcase
			eff = (cnt == 0) ? 1 : ((cnt > CountCap) ? CountCap : int'(cnt));
			case ($urandom_range(0, 5))
				0:       msk = '0;
				1:       msk = '1;
				2:       msk = MaskW'($urandom);
				3:       msk = ~(16'h0001 << $urandom_range(0, 15));
				4:       msk = 16'($urandom) | 16'((1 << eff) - 1);
				default: msk = 16'($urandom) & 16'($urandom);
			endcase
			set_registers(m, cnt, msk, 1'b0);

			for (int w = 0; w < WordsPerPhase; w++) begin
				if (!quiet_tail && $urandom_range(0, 49) == 0)
					drain_results();
				else if (!quiet_tail && !calm_phase && $urandom_range(0, 3) == 0)
					pause_sender($urandom_range(1, 4));
				case ($urandom_range(0, 3))
					0:       h = $urandom_range(0, 63);
					1:       h = 32'hFFFF_FFFF - $urandom_range(0, 63);
					default: h = $urandom;
				endcase
				send_word(h, 1'b0, '0);
			end
		end

		// Wind down: wait for the last words, then allow stray ones to show
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_choices.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		mismatches += pending_choices.size();

		$display("Sent %0d request words (%0d from the directed table) under %0d register settings,",
			words_sent, NumProbes, settings_written);
		$display("both modes, counts from zero to 31 and masks from empty to full; %0d words checked.",
			words_checked);
		if (mismatches == 0)
			$display("[lb_endpoint_selector_top] OK");
		else
			$display("[lb_endpoint_selector_top] ERROR");
		$finish;
	end

endmodule

// File: lb_endpoint_selector_top.f
rtl/core/lbes_pkg.sv
rtl/core/lbes_if.sv
rtl/core/lbes_cfg.sv
rtl/core/lbes_datapath.sv
rtl/core/lbes_ctrl.sv
rtl/core/lb_endpoint_selector_top.sv
sim/lb_endpoint_selector_top_test.sv
